>>> sv/e2r_pkg.sv
// Shared types and fixed-point constants for the Euler angle to rotation matrix block.
package e2r_pkg;

    // Internal working format: signed Q30 held in 32 bits (range -2 to just under +2)
    localparam int Q_FRAC = 30;
    typedef logic signed [31:0] t_q30;

    localparam logic [30:0] Q_ONE = 31'(64'd1 << Q_FRAC);

endpackage

>>> sv/e2r_sincos.sv
// Pipelined sine/cosine of one Q-format angle: quadrant reduction plus Horner series, Q30 out.
module e2r_sincos
    import e2r_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 12
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [ANGLE_FRAC_BITS+2:0] i_angle,
    output t_q30                         o_sin,
    output t_q30                         o_cos
);

    localparam int AW    = ANGLE_FRAC_BITS + 3;
    localparam int NSTEP = 7;
    localparam int SIDE  = 3 * NSTEP;

    localparam logic [32:0] HP = 33'd1686629713;   // pi/2 in Q30
    localparam logic [32:0] T1 = HP - HP / 2;
    localparam logic [32:0] T2 = 2 * HP - HP / 2;
    localparam logic [32:0] T3 = 3 * HP - HP / 2;

    localparam logic [7:0] D_C [NSTEP] = '{8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
    localparam logic [7:0] D_S [NSTEP-1] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [31:0] M_C [NSTEP] = '{
        32'(64'd4294967296 / 64'd182), 32'(64'd4294967296 / 64'd132),
        32'(64'd4294967296 / 64'd90),  32'(64'd4294967296 / 64'd56),
        32'(64'd4294967296 / 64'd30),  32'(64'd4294967296 / 64'd12),
        32'(64'd4294967296 / 64'd2)};
    localparam logic [31:0] M_S [NSTEP-1] = '{
        32'(64'd4294967296 / 64'd156), 32'(64'd4294967296 / 64'd110),
        32'(64'd4294967296 / 64'd72),  32'(64'd4294967296 / 64'd42),
        32'(64'd4294967296 / 64'd20),  32'(64'd4294967296 / 64'd6)};

    // stage 1: magnitude, scale to Q30, quadrant
    logic          s1_neg;
    logic [AW-1:0] s1_mag;
    logic [32:0]   s1_a;
    logic [1:0]    s1_q;
    logic [32:0]   r1_a;
    logic [1:0]    r1_q;
    logic          r1_neg;

    assign s1_neg = i_angle[AW-1];
    assign s1_mag = s1_neg ? AW'(-i_angle) : AW'(i_angle);
    assign s1_a   = 33'(s1_mag) << (Q_FRAC - ANGLE_FRAC_BITS);

    always_comb begin
        priority if (s1_a >= T3) s1_q = 2'd3;
        else if (s1_a >= T2)     s1_q = 2'd2;
        else if (s1_a >= T1)     s1_q = 2'd1;
        else                     s1_q = 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_a   <= s1_a;
            r1_q   <= s1_q;
            r1_neg <= s1_neg;
        end
    end

    // stage 2: remainder about the nearest multiple of pi/2
    logic [32:0]        s2_qhp;
    logic signed [33:0] s2_r;
    logic [29:0]        r2_x;
    logic               r2_rneg;
    logic [1:0]         r2_q;
    logic               r2_neg;

    always_comb begin
        unique case (r1_q)
            2'd0: s2_qhp = 33'd0;
            2'd1: s2_qhp = HP;
            2'd2: s2_qhp = 33'(2 * HP);
            2'd3: s2_qhp = 33'(3 * HP);
            default: s2_qhp = 33'd0;
        endcase
    end

    assign s2_r = $signed({1'b0, r1_a}) - $signed({1'b0, s2_qhp});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_x    <= s2_r[33] ? 30'(-s2_r) : 30'(s2_r);
            r2_rneg <= s2_r[33];
            r2_q    <= r1_q;
            r2_neg  <= r1_neg;
        end
    end

    // stage 3: x^2 in Q30; side pipes carry x, x^2 and sign flags along the series
    logic [59:0] s3_xx;
    logic [29:0] r_x    [0:SIDE];
    logic [29:0] r_x2   [0:SIDE];
    logic [1:0]  r_q    [0:SIDE];
    logic        r_neg  [0:SIDE];
    logic        r_rneg [0:SIDE];

    assign s3_xx = 60'(r2_x) * 60'(r2_x);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= r2_x;
            r_x2[0]   <= s3_xx[59:30];
            r_q[0]    <= r2_q;
            r_neg[0]  <= r2_neg;
            r_rneg[0] <= r2_rneg;
        end
    end

    genvar g;
    for (g = 0; g < SIDE; g++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[g+1]    <= r_x[g];
                r_x2[g+1]   <= r_x2[g];
                r_q[g+1]    <= r_q[g];
                r_neg[g+1]  <= r_neg[g];
                r_rneg[g+1] <= r_rneg[g];
            end
        end
    end

    // Horner steps, three stages each: multiply, reciprocal multiply, correct and subtract
    logic [29:0] r_cp  [0:NSTEP-1];
    logic [61:0] r_cpm [0:NSTEP-1];
    logic [29:0] r_cq  [0:NSTEP-1];
    logic [30:0] r_ct  [1:NSTEP];
    logic [29:0] r_sp  [0:NSTEP-1];
    logic [61:0] r_spm [0:NSTEP-2];
    logic [29:0] r_sq  [0:NSTEP-1];
    logic [30:0] r_st  [1:NSTEP];

    genvar k;
    for (k = 0; k < NSTEP; k++) begin : g_step
        logic [30:0] ct_in;
        logic [30:0] st_in;
        logic [60:0] c_prod;
        logic [29:0] c_q0;
        logic [39:0] c_rem;

        if (k == 0) begin : g_first
            assign ct_in = Q_ONE;
            assign st_in = Q_ONE;
        end else begin : g_next
            assign ct_in = r_ct[k];
            assign st_in = r_st[k];
        end

        assign c_prod = 61'(r_x2[3*k]) * 61'(ct_in);
        assign c_q0   = r_cpm[k][61:32];
        assign c_rem  = 40'(r_cq[k]) - 40'(c_q0) * 40'(D_C[k]);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_cp[k]    <= c_prod[59:30];
                r_cpm[k]   <= 62'(r_cp[k]) * 62'(M_C[k]);
                r_cq[k]    <= r_cp[k];
                // reciprocal quotient is low by at most one
                r_ct[k+1]  <= Q_ONE - (31'(c_q0) + 31'(c_rem >= 40'(D_C[k])));
            end
        end

        if (k < NSTEP - 1) begin : g_sin
            logic [60:0] s_prod;
            logic [29:0] s_q0;
            logic [39:0] s_rem;

            assign s_prod = 61'(r_x2[3*k]) * 61'(st_in);
            assign s_q0   = r_spm[k][61:32];
            assign s_rem  = 40'(r_sq[k]) - 40'(s_q0) * 40'(D_S[k]);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sp[k]   <= s_prod[59:30];
                    r_spm[k]  <= 62'(r_sp[k]) * 62'(M_S[k]);
                    r_sq[k]   <= r_sp[k];
                    r_st[k+1] <= Q_ONE - (31'(s_q0) + 31'(s_rem >= 40'(D_S[k])));
                end
            end
        end else begin : g_sin_last
            // sine series ends one step early: final x*t, then two pass stages
            logic [60:0] s_prod;

            assign s_prod = 61'(r_x[3*k]) * 61'(st_in);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sp[k]   <= s_prod[59:30];
                    r_sq[k]   <= r_sp[k];
                    r_st[k+1] <= {1'b0, r_sq[k]};
                end
            end
        end
    end

    // final stage: quadrant and sign fix-up
    t_q30 f_s0;
    t_q30 f_c0;
    t_q30 f_so;
    t_q30 f_co;
    t_q30 r_sin;
    t_q30 r_cos;

    always_comb begin
        f_c0 = t_q30'(r_ct[NSTEP]);
        f_s0 = r_rneg[SIDE] ? -t_q30'(r_st[NSTEP]) : t_q30'(r_st[NSTEP]);
        unique case (r_q[SIDE])
            2'd0: begin f_so = f_s0;  f_co = f_c0;  end
            2'd1: begin f_so = f_c0;  f_co = -f_s0; end
            2'd2: begin f_so = -f_s0; f_co = -f_c0; end
            2'd3: begin f_so = -f_c0; f_co = f_s0;  end
            default: begin f_so = f_s0; f_co = f_c0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= r_neg[SIDE] ? -f_so : f_so;
            r_cos <= f_co;
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

>>> sv/euler_to_rotation_matrix.sv
// Euler angles to 3x3 rotation matrix: stream in, stream out, fully pipelined.
//
// Input channel (i_s_*): one transaction carries angle_x, angle_y, angle_z in tdata
// (signed radians, ANGLE_FRAC_BITS fraction bits) and order_xyz in tuser.
// order_xyz = 0 gives Rz*Ry*Rx, 1 gives Rx*Ry*Rz.
// Output channel (o_m_*): one transaction per input with the nine elements,
// row-major, signed with ELEM_FRAC_BITS fraction bits, saturated to +/-1.
//
// Throughput: one transaction per cycle unless a receiver stall freezes the pipe. The
// path from input acceptance to o_m_tvalid runs through the sine/cosine pipes (seven
// three-stage Horner steps), the two matrix products and the output register.
// The block holds no state between transactions.
// Reset clears all valid bits; in-flight transactions are dropped.
// When the receiver stalls, the result holds in the output register and one more
// lands in a skid register; after that o_s_tready drops and the whole pipe
// freezes until the output is taken.
module euler_to_rotation_matrix
    import e2r_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 12,
    parameter int ELEM_FRAC_BITS  = 14
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_s_tvalid,
    output logic                                     o_s_tready,
    // angle_x, angle_y, angle_z, zero pad
    input  logic [((3*(ANGLE_FRAC_BITS+3)+7)/8)*8-1:0] i_s_tdata,
    // order_xyz
    input  logic [0:0]                               i_s_tuser,
    output logic                                     o_m_tvalid,
    input  logic                                     i_m_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22, zero pad
    output logic [((9*(ELEM_FRAC_BITS+2)+7)/8)*8-1:0] o_m_tdata
);

    localparam int AW     = ANGLE_FRAC_BITS + 3;
    localparam int OW     = ELEM_FRAC_BITS + 2;
    localparam int TDW    = ((9 * OW + 7) / 8) * 8;
    localparam int SC_LAT = 25;
    localparam int L      = SC_LAT + 4;
    localparam int SH     = Q_FRAC - ELEM_FRAC_BITS;
    localparam logic signed [33:0] LIM = 34'sd1 <<< ELEM_FRAC_BITS;

    function automatic logic signed [63:0] mul(input t_q30 a, input t_q30 b);
        return 64'(a) * 64'(b);
    endfunction

    // round Q60 to Q30, ties up
    function automatic t_q30 rnd30(input logic signed [64:0] v);
        logic signed [64:0] w;
        w = (v + 65'sd536870912) >>> Q_FRAC;
        return w[31:0];
    endfunction

    // round Q30 to the output format, ties up, then saturate
    function automatic logic [OW-1:0] fin(input t_q30 v);
        logic signed [33:0] w;
        w = ((34'(v) <<< 1) + (34'sd1 <<< SH)) >>> (SH + 1);
        if (w > LIM) w = LIM;
        else if (w < -LIM) w = -LIM;
        return w[OW-1:0];
    endfunction

    logic en;
    logic [L-1:0] r_vld;
    logic [SC_LAT-1:0] r_ord_sr;
    logic r_out_vld;
    logic r_skid_vld;

    assign en         = !r_skid_vld;
    assign o_s_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[L-2:0], i_s_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) r_ord_sr <= {r_ord_sr[SC_LAT-2:0], i_s_tuser[0]};
    end

    t_q30 sx, cx, sy, cy, sz, cz;

    e2r_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_sc_x (
        .i_clk(i_clk), .i_en(en), .i_angle($signed(i_s_tdata[AW-1:0])),
        .o_sin(sx), .o_cos(cx));
    e2r_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_sc_y (
        .i_clk(i_clk), .i_en(en), .i_angle($signed(i_s_tdata[2*AW-1:AW])),
        .o_sin(sy), .o_cos(cy));
    e2r_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_sc_z (
        .i_clk(i_clk), .i_en(en), .i_angle($signed(i_s_tdata[3*AW-1:2*AW])),
        .o_sin(sz), .o_cos(cz));

    // P1: inner product terms of Ry with the inner rotation (Rx or Rz)
    logic               s1_ord;
    t_q30               s1_cu, s1_su;
    logic signed [63:0] r1_pcc, r1_pcs, r1_psc, r1_pss;
    t_q30               r1_cy, r1_sy, r1_cu, r1_su, r1_co, r1_so;
    logic               r1_ord;

    assign s1_ord = r_ord_sr[SC_LAT-1];
    assign s1_cu  = s1_ord ? cz : cx;
    assign s1_su  = s1_ord ? sz : sx;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_pcc <= mul(cy, s1_cu);
            r1_pcs <= mul(cy, s1_su);
            r1_psc <= mul(sy, s1_cu);
            r1_pss <= mul(sy, s1_su);
            r1_cy  <= cy;
            r1_sy  <= sy;
            r1_cu  <= s1_cu;
            r1_su  <= s1_su;
            r1_co  <= s1_ord ? cx : cz;
            r1_so  <= s1_ord ? sx : sz;
            r1_ord <= s1_ord;
        end
    end

    // P2: round and lay out the first product matrix
    t_q30 s2_t  [0:2][0:2];
    t_q30 r2_t  [0:2][0:2];
    t_q30 r2_co, r2_so;
    logic r2_ord;

    always_comb begin
        if (!r1_ord) begin
            s2_t[0][0] = r1_cy;
            s2_t[0][1] = rnd30(65'(r1_pss));
            s2_t[0][2] = rnd30(65'(r1_psc));
            s2_t[1][0] = '0;
            s2_t[1][1] = r1_cu;
            s2_t[1][2] = -r1_su;
            s2_t[2][0] = -r1_sy;
            s2_t[2][1] = rnd30(65'(r1_pcs));
            s2_t[2][2] = rnd30(65'(r1_pcc));
        end else begin
            s2_t[0][0] = rnd30(65'(r1_pcc));
            s2_t[0][1] = rnd30(-65'(r1_pcs));
            s2_t[0][2] = r1_sy;
            s2_t[1][0] = r1_su;
            s2_t[1][1] = r1_cu;
            s2_t[1][2] = '0;
            s2_t[2][0] = rnd30(-65'(r1_psc));
            s2_t[2][1] = rnd30(65'(r1_pss));
            s2_t[2][2] = r1_cy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_t   <= s2_t;
            r2_co  <= r1_co;
            r2_so  <= r1_so;
            r2_ord <= r1_ord;
        end
    end

    // P3: outer rotation acts on two rows (0,1 for order 0; 1,2 for order 1)
    logic signed [63:0] r3_pa1 [0:2];
    logic signed [63:0] r3_pa2 [0:2];
    logic signed [63:0] r3_pb1 [0:2];
    logic signed [63:0] r3_pb2 [0:2];
    t_q30               r3_pass [0:2];
    logic               r3_ord;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                r3_pa1[j]  <= mul(r2_co, r2_ord ? r2_t[1][j] : r2_t[0][j]);
                r3_pa2[j]  <= mul(-r2_so, r2_ord ? r2_t[2][j] : r2_t[1][j]);
                r3_pb1[j]  <= mul(r2_so, r2_ord ? r2_t[1][j] : r2_t[0][j]);
                r3_pb2[j]  <= mul(r2_co, r2_ord ? r2_t[2][j] : r2_t[1][j]);
                r3_pass[j] <= r2_ord ? r2_t[0][j] : r2_t[2][j];
            end
            r3_ord <= r2_ord;
        end
    end

    // P4: sum and round to Q30, back into row order
    t_q30 r4_m [0:2][0:2];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                if (!r3_ord) begin
                    r4_m[0][j] <= rnd30(65'(r3_pa1[j]) + 65'(r3_pa2[j]));
                    r4_m[1][j] <= rnd30(65'(r3_pb1[j]) + 65'(r3_pb2[j]));
                    r4_m[2][j] <= r3_pass[j];
                end else begin
                    r4_m[0][j] <= r3_pass[j];
                    r4_m[1][j] <= rnd30(65'(r3_pa1[j]) + 65'(r3_pa2[j]));
                    r4_m[2][j] <= rnd30(65'(r3_pb1[j]) + 65'(r3_pb2[j]));
                end
            end
        end
    end

    // final rounding into the output register or skid register
    logic [9*OW-1:0] s5_res;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                s5_res[(i*3+j)*OW +: OW] = fin(r4_m[i][j]);
            end
        end
    end

    logic            out_take;
    logic            pipe_vld;
    logic            n_out_vld, n_skid_vld;
    logic            load_out, load_skid, out_from_skid;
    logic [9*OW-1:0] r_out_data, r_skid_data;

    assign out_take = r_out_vld && i_m_tready;
    assign pipe_vld = r_vld[L-1];

    always_comb begin
        n_out_vld     = r_out_vld;
        n_skid_vld    = r_skid_vld;
        load_out      = 1'b0;
        load_skid     = 1'b0;
        out_from_skid = 1'b0;
        priority if (r_skid_vld) begin
            if (out_take) begin
                out_from_skid = 1'b1;
                n_skid_vld    = 1'b0;
            end
        end else if (pipe_vld) begin
            if (!r_out_vld || out_take) begin
                load_out  = 1'b1;
                n_out_vld = 1'b1;
            end else begin
                load_skid  = 1'b1;
                n_skid_vld = 1'b1;
            end
        end else if (out_take) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) r_out_data <= s5_res;
        else if (out_from_skid) r_out_data <= r_skid_data;
        if (load_skid) r_skid_data <= s5_res;
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = TDW'(r_out_data);

    // skid register only fills behind a held output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid register valid with empty output register");

    // a frozen pipe keeps its valid bits
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline valid bits moved during stall");

    // a finished result is never dropped
    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pipe_vld && en) |=> (r_out_vld && (r_skid_vld || !$past(r_out_vld) ||
                                            $past(i_m_tready))))
        else $error("pipeline result lost at output");

endmodule

>>> tb/euler_to_rotation_matrix_tb.sv
// Self-checking testbench for the Euler angle to rotation matrix stream block.
`timescale 1ns / 100ps

module euler_to_rotation_matrix_tb
    import e2r_pkg::*;
();

    localparam int AFB = 12;
    localparam int EFB = 14;
    localparam int AW  = AFB + 3;
    localparam int OW  = EFB + 2;
    localparam int IN_BITS  = ((3 * AW + 7) / 8) * 8;
    localparam int OUT_BITS = ((9 * OW + 7) / 8) * 8;
    localparam longint unsigned HALF_PI = 64'd1686629713;
    localparam longint ONE_Q30 = 64'sd1 << Q_FRAC;
    localparam int LATENCY = 30;

    typedef logic [8:0][OW-1:0] t_matrix;
    typedef longint t_m3[3][3];

    logic                i_clk;
    logic                i_rst_n;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [IN_BITS-1:0]  i_s_tdata;   // angle_x, angle_y, angle_z, zero pad
    logic [0:0]          i_s_tuser;   // order_xyz
    logic                o_m_tvalid;
    logic                i_m_tready;
    logic [OUT_BITS-1:0] o_m_tdata;   // m00 .. m22 row-major, zero pad

    t_matrix expected_matrices[$];
    int      error_count;
    int      sent_count;
    int      checked_count;
    bit      quiet;
    int      hold_cycles;

    euler_to_rotation_matrix #(.ANGLE_FRAC_BITS(AFB), .ELEM_FRAC_BITS(EFB)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // floor(v / 2^sh) after adding half: ties go up
    function automatic longint round_q(longint v, int sh);
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    task automatic sin_cos(input logic signed [AW-1:0] ang, output longint s, output longint c);
        longint unsigned mag, a, q, x, x2, t;
        longint r, s0, c0, so, co;
        longint unsigned dsin[6];
        longint unsigned dcos[7];
        dsin = '{156, 110, 72, 42, 20, 6};
        dcos = '{182, 132, 90, 56, 30, 12, 2};
        mag = (ang < 0) ? longint'(-longint'(ang)) : longint'(ang);
        a = mag << (Q_FRAC - AFB);
        q = (a + HALF_PI / 2) / HALF_PI;
        r = longint'(a) - longint'(q * HALF_PI);
        x = (r < 0) ? -r : r;
        x2 = (x * x) >> 30;
        t = ONE_Q30;
        for (int i = 0; i < 6; i++) t = ONE_Q30 - ((x2 * t) >> 30) / dsin[i];
        s0 = longint'((x * t) >> 30);
        if (r < 0) s0 = -s0;
        t = ONE_Q30;
        for (int i = 0; i < 7; i++) t = ONE_Q30 - ((x2 * t) >> 30) / dcos[i];
        c0 = longint'(t);
        case (q[1:0])
            2'd0: begin so = s0;  co = c0;  end
            2'd1: begin so = c0;  co = -s0; end
            2'd2: begin so = -s0; co = -c0; end
            default: begin so = -c0; co = s0; end
        endcase
        s = (ang < 0) ? -so : so;
        c = co;
    endtask

    function automatic t_m3 mat_mul(t_m3 a, t_m3 b);
        t_m3 m;
        longint acc;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                acc = 0;
                for (int k = 0; k < 3; k++) acc += a[i][k] * b[k][j];
                m[i][j] = round_q(acc, Q_FRAC);
            end
        return m;
    endfunction

    task automatic predict_rotation(input logic signed [AW-1:0] ax, ay, az, input logic ord,
                                    output t_matrix res);
        longint sx, cx, sy, cy, sz, cz, v;
        t_m3 rx, ry, rz, m;
        sin_cos(ax, sx, cx);
        sin_cos(ay, sy, cy);
        sin_cos(az, sz, cz);
        rx = '{'{ONE_Q30, 0, 0}, '{0, cx, -sx}, '{0, sx, cx}};
        ry = '{'{cy, 0, sy}, '{0, ONE_Q30, 0}, '{-sy, 0, cy}};
        rz = '{'{cz, -sz, 0}, '{sz, cz, 0}, '{0, 0, ONE_Q30}};
        m = ord ? mat_mul(rx, mat_mul(ry, rz)) : mat_mul(rz, mat_mul(ry, rx));
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                v = round_q(m[i][j], Q_FRAC - EFB);
                if (v > (64'sd1 << EFB)) v = 64'sd1 << EFB;
                if (v < -(64'sd1 << EFB)) v = -(64'sd1 << EFB);
                res[i * 3 + j] = v[OW-1:0];
            end
    endtask

    task automatic send_angles(input logic signed [AW-1:0] ax, ay, az, input logic ord);
        t_matrix res;
        if (!quiet) begin
            while ($urandom_range(99) < 9) begin
                i_s_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= IN_BITS'({az, ay, ax});
        i_s_tuser  <= ord;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_rotation(ax, ay, az, ord, res);
        expected_matrices = {expected_matrices, res};
        sent_count++;
    endtask

    function automatic logic signed [AW-1:0] rand_angle();
        if ($urandom_range(3) == 0) return AW'($urandom);
        return AW'($signed($urandom_range(2 * 12868)) - 12868);
    endfunction

    // result checker
    initial begin
        t_matrix want;
        t_matrix got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                got = o_m_tdata[9*OW-1:0];
                if (expected_matrices.size() == 0) begin
                    $error("unexpected result transaction %h", got);
                    error_count++;
                end else begin
                    want = expected_matrices.pop_front();
                    for (int k = 0; k < 9; k++)
                        if (got[k] !== want[k]) begin
                            $error("m%0d%0d: expected %0d actual %0d", k / 3, k % 3,
                                   $signed(want[k]), $signed(got[k]));
                            error_count++;
                        end
                    checked_count++;
                end
            end
        end
    end

    // receiver ready, with optional long hold-off
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                i_m_tready <= 1'b0;
                hold_cycles--;
            end else begin
                i_m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 9);
            end
        end
    end

    task automatic wait_drained();
        while (expected_matrices.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        logic signed [AW-1:0] corner[10];
        corner = '{0, 12868, -12868, 6434, -6434, 3217, 16383, -16384, 1, -1};
        for (int i = 0; i < 10; i++)
            send_angles(corner[i], corner[(i + 3) % 10], corner[(i + 7) % 10], i[0]);
        send_angles(12868, 12868, 12868, 1'b0);
        send_angles(-12868, -12868, -12868, 1'b1);
        send_angles(6434, 6434, 6434, 1'b0);
        send_angles(6434, 6434, 6434, 1'b1);
        send_angles(16383, -16384, 16383, 1'b0);
        send_angles(-16384, 16383, -16384, 1'b1);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_angles(rand_angle(), rand_angle(), rand_angle(), 1'($urandom_range(1)));
    endtask

    task automatic test_quiet_stretch();
        quiet = 1'b1;
        test_random(150);
        quiet = 1'b0;
    endtask

    task automatic test_backpressure();
        hold_cycles = 200;
        test_random(80);
    endtask

    task automatic test_drain_pause();
        i_s_tvalid <= 1'b0;
        wait_drained();
        @(posedge i_clk);
        test_random(50);
    endtask

    initial begin
        error_count = 0;
        sent_count = 0;
        checked_count = 0;
        quiet = 1'b0;
        hold_cycles = 0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(300);
        test_quiet_stretch();
        test_backpressure();
        test_drain_pause();
        test_random(150);
        i_s_tvalid <= 1'b0;
        wait_drained();
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("Sent %0d angle sets in both orders, corners and out-of-range angles,",
                 sent_count);
        $display("with random and long output stalls; %0d matrices checked.", checked_count);
        if (error_count == 0 && expected_matrices.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
